// ===== hw/rtl/rlbs_pkg.sv =====
`timescale 1ns / 1ps

package rlbs_pkg;

   localparam int NUM_CHAN = 3;

   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_SET_EXCL   = 2'd1;
   localparam logic [1:0] OP_SET_SINGLE = 2'd2;

   localparam logic [2:0] COL_RED   = 3'd0;
   localparam logic [2:0] COL_GREEN = 3'd1;
   localparam logic [2:0] COL_BLUE  = 3'd2;
   localparam logic [2:0] COL_WHITE = 3'd3;
   localparam logic [2:0] COL_OFF   = 3'd4;

   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_ON     = 2'd1;
   localparam logic [1:0] MODE_ONCE   = 2'd2;
   localparam logic [1:0] MODE_REPEAT = 2'd3;

   localparam logic [15:0] END_RUN   = 16'd1000;
   localparam logic [15:0] END_FLASH = 16'd500;
   localparam logic [15:0] MIN_FLASH = 16'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  color;
      logic [1:0]  mode;
      logic [15:0] run_time;
      logic [15:0] flash_time;
      logic [2:0]  after_color;
   } item_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] count;
      logic [15:0] period;
      logic [15:0] off_pt;
      logic        lit;
   } channel_type;

   typedef struct packed {
      channel_type [NUM_CHAN-1:0] chan;
      logic [2:0]                 pending;
   } seq_state_type;

   function automatic channel_type load_chan(input channel_type c, input logic [1:0] m,
                                             input logic [15:0] run, input logic [15:0] fl);
      channel_type r;
      logic [15:0] p;
      logic [15:0] f;
      r = c;
      p = run + 16'd1;
      f = fl;
      case (m)
         MODE_OFF: begin
            p = 16'd1;
            f = 16'd1;
         end
         MODE_ON: begin
            p = 16'd2;
            f = 16'd2;
         end
         default: begin
            if (f < MIN_FLASH) f = MIN_FLASH;
            else if (f > p) f = p;
         end
      endcase
      // flash-once on top of a running flash-once is ignored
      if (!(m == MODE_ONCE && c.mode == MODE_ONCE)) begin
         r.mode   = m;
         r.count  = p;
         r.period = p;
         r.off_pt = p - f;
      end
      return r;
   endfunction

   function automatic seq_state_type set_excl(input seq_state_type s, input logic [2:0] col,
                                              input logic [1:0] m, input logic [15:0] run,
                                              input logic [15:0] fl, input logic [2:0] after);
      seq_state_type r;
      logic [1:0] cm;
      r = s;
      r.pending = after;
      if (col <= COL_OFF) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            cm = (col == COL_WHITE || col == 3'(i)) ? m : MODE_OFF;
            r.chan[i] = load_chan(s.chan[i], cm, run, fl);
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/rlbs_cmd.sv =====
`timescale 1ns / 1ps

module rlbs_cmd (
   input  rlbs_pkg::item_type      item,
   input  rlbs_pkg::seq_state_type st_in,
   output rlbs_pkg::seq_state_type st_out
);
   import rlbs_pkg::*;

   always_comb begin
      st_out = st_in;
      case (item.op)
         OP_SET_EXCL: begin
            st_out = set_excl(st_in, item.color, item.mode, item.run_time,
                              item.flash_time, item.after_color);
         end
         OP_SET_SINGLE: begin
            st_out.pending = item.after_color;
            if (item.color < COL_WHITE) begin
               st_out.chan[item.color[1:0]] = load_chan(st_in.chan[item.color[1:0]],
                  item.mode, item.run_time, item.flash_time);
            end else if (item.color == COL_WHITE) begin
               for (int i = 0; i < NUM_CHAN; i++) begin
                  st_out.chan[i] = load_chan(st_in.chan[i], item.mode, item.run_time,
                                             item.flash_time);
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/rlbs_tick_stage.sv =====
`timescale 1ns / 1ps

module rlbs_tick_stage (
   input  logic [1:0]              stage_idx,
   input  rlbs_pkg::seq_state_type st_in,
   output rlbs_pkg::seq_state_type st_out
);
   import rlbs_pkg::*;

   always_comb begin
      channel_type c;
      logic [15:0] cnt;
      st_out = st_in;
      c      = st_in.chan[stage_idx];
      cnt    = c.count - 16'd1;
      if (c.count != 16'd0) begin
         c.count = cnt;
         if (cnt == 16'd0) begin
            case (c.mode)
               MODE_OFF:    c.lit = 1'b0;
               MODE_ON:     c.lit = 1'b1;
               MODE_ONCE:   ;
               MODE_REPEAT: c.count = c.period;
               default:     ;
            endcase
         end else if (cnt == c.off_pt) begin
            c.lit = 1'b0;
         end else if (cnt == c.period - 16'd1) begin
            c.lit = 1'b1;
         end
         st_out.chan[stage_idx] = c;
         // end of flash-once: exclusive steady-on of the pending colour,
         // seen by the stages that follow
         if (cnt == 16'd0 && c.mode == MODE_ONCE) begin
            st_out = set_excl(st_out, st_in.pending, MODE_ON, END_RUN, END_FLASH, COL_OFF);
         end
      end
   end

endmodule

// ===== hw/rtl/rgb_led_blink_sequencer.sv =====
`timescale 1ns / 1ps

// RGB lamp blink sequencer.
// req_ channel: one beat is a tick (op 0) or a colour command (op 1 exclusive,
// op 2 single channel or white); op 3 changes nothing. Every request beat gives
// exactly one rsp_ beat carrying the three lamp states after that beat.
// A request is taken into an input register; once the result register is free
// or being read, the command load or the red, green, blue tick chain updates
// the channel state and the lamp result register together, and rsp_valid
// rises with that result. One beat per cycle is sustained while rsp_ready stays
// high, the limit being the single state update per cycle.
// rsp_ stall: the result register holds, the input register fills, and
// req_ready drops once both are occupied; no beat is lost.
// Reset (synchronous, active high): all channels steady off, counters idle,
// lit flags clear, pending after-colour off, both channels empty.
// Lamp outputs are 1 for lit; pin polarity is left to the user.

module rgb_led_blink_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_color,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_run_time,
   input  logic [15:0] req_flash_time,
   input  logic [2:0]  req_after_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_lamp_red,
   output logic        rsp_lamp_green,
   output logic        rsp_lamp_blue
);
   import rlbs_pkg::*;

   logic          in_valid_ff, in_valid_in;
   item_type      in_item_ff;
   seq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_lamp_ff, rsp_lamp_in;
   logic          advance;
   seq_state_type cmd_st;
   seq_state_type tick_st [NUM_CHAN];

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   rlbs_cmd u_cmd (
      .item   (in_item_ff),
      .st_in  (state_ff),
      .st_out (cmd_st)
   );

   rlbs_tick_stage u_tick_red (
      .stage_idx (2'd0),
      .st_in     (state_ff),
      .st_out    (tick_st[0])
   );

   rlbs_tick_stage u_tick_green (
      .stage_idx (2'd1),
      .st_in     (tick_st[0]),
      .st_out    (tick_st[1])
   );

   rlbs_tick_stage u_tick_blue (
      .stage_idx (2'd2),
      .st_in     (tick_st[1]),
      .st_out    (tick_st[2])
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_lamp_in  = rsp_lamp_ff;
      if (advance) begin
         state_in     = (in_item_ff.op == OP_TICK) ? tick_st[2] : cmd_st;
         rsp_valid_in = 1'b1;
         rsp_lamp_in  = {state_in.chan[2].lit, state_in.chan[1].lit, state_in.chan[0].lit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{chan: '0, pending: COL_OFF};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{op: req_op, color: req_color, mode: req_mode,
                         run_time: req_run_time, flash_time: req_flash_time,
                         after_color: req_after_color};
      end
      rsp_lamp_ff <= rsp_lamp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lamp_red   = rsp_lamp_ff[0];
   assign rsp_lamp_green = rsp_lamp_ff[1];
   assign rsp_lamp_blue  = rsp_lamp_ff[2];

   a_in_held : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input beat dropped while result stage stalled");

   a_adv_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat produced no result");

   a_rsp_mirror : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_lamp_ff == {state_ff.chan[2].lit, state_ff.chan[1].lit,
                                       state_ff.chan[0].lit})
      else $error("result lamps differ from channel state");

   a_off_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff.chan[0].mode != MODE_OFF || state_ff.chan[0].count <= 16'd1) &&
      (state_ff.chan[1].mode != MODE_OFF || state_ff.chan[1].count <= 16'd1) &&
      (state_ff.chan[2].mode != MODE_OFF || state_ff.chan[2].count <= 16'd1))
      else $error("steady-off channel holds a long count");

endmodule
